@@ rtl/msbbuf_pkg.sv @@
// Shared types and constants for the MSB-first bit stream buffer.
// Holds request and status codes, controller states and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msbbuf_pkg;

    // Default number of bytes in the byte store.
    localparam int STORE_BYTES_DEF = 4096;

    // Field widths.
    localparam int CUR_BYTE_W = 13;
    localparam int CUR_BIT_W  = 4;
    localparam int CNT_W      = 16;
    localparam int VALUE_W    = 64;
    localparam int OFF_W      = 17;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;

    // Capacity register after reset.
    localparam logic [CUR_BYTE_W-1:0] CAP_RESET = 13'd4096;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_SEEK  = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RD,
        S_WA,
        S_WB,
        S_WC,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

@@ rtl/msb_first_bit_stream_buffer_top.sv @@
// Top level of the MSB-first bit stream buffer: byte store, bit cursor,
// request sequencer and result register. Depends on msbbuf_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Signals                          Content
//  s         in         i_s_tvalid/o_s_tready            one request word
//  m         out        o_m_tvalid/i_m_tready            one result word
//  cfg       in         i_cfg_valid/o_cfg_ready          capacity_bytes write
//
//  A request is taken in idle and evaluated; seek and space query then go to the
//  final state, a write reads and updates one byte (or two when its bits span two),
//  and a read fetches the nb store bytes its bits span (up to 9) and shifts them in.
//  The single port of the byte store carries one byte per cycle.
//  Reset clears the cursor, sets capacity to 4096 and needs no memory pass.
//  A result waits in the output register; a new request is taken meanwhile, and
//  its result waits in the final state until the register is free.
module msb_first_bit_stream_buffer_top #(
    parameter int STORE_BYTES = msbbuf_pkg::STORE_BYTES_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // Request channel.
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: write_byte [7:0], bit_count [23:8]
    input  wire  [msbbuf_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser: req_type [1:0]
    input  wire  [1:0]                             i_s_tuser,
    // Result channel.
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    // tdata: read_value [63:0], status [65:64], byte_position [78:66],
    //        bit_position [82:79], zero fill [87:83]
    output logic [msbbuf_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // Configuration channel: capacity_bytes.
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [msbbuf_pkg::CUR_BYTE_W-1:0]      i_cfg_data
);
    import msbbuf_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [OFF_W-1:0] STORE_LIM = OFF_W'(STORE_BYTES);

    // Byte store.
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_q;
    logic       r_q_valid;

    // Control and cursor registers.
    t_state                r_state, n_state;
    logic [CUR_BYTE_W-1:0] r_capacity;
    logic [CUR_BYTE_W-1:0] r_cur_byte;
    logic [CUR_BIT_W-1:0]  r_cur_bit;

    // Latched request.
    t_req             r_req;
    logic [7:0]       r_wbyte;
    logic [CNT_W-1:0] r_n;

    // Per-request working registers.
    t_status               r_res_status;
    logic [CUR_BYTE_W-1:0] r_res_byte;
    logic [CUR_BIT_W-1:0]  r_res_bit;
    logic                  r_val_en;
    logic [AW-1:0]         r_addr;
    logic [2:0]            r_p;
    logic [2:0]            r_drop;
    logic [3:0]            r_issue_left;
    logic [3:0]            r_cap_left;
    logic                  r_first;
    logic [71:0]           r_acc;
    logic [15:0]           r_wd;
    logic [15:0]           r_wm;

    // Output register.
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    t_status               r_out_status;
    logic [CUR_BYTE_W-1:0] r_out_byte;
    logic [CUR_BIT_W-1:0]  r_out_bit;

    // Request evaluation.
    logic [OFF_W-1:0]      off_cur, cap_eff, cap_bits, free_bits, n17;
    logic [OFF_W-1:0]      end_m1, seek_off;
    logic                  over_free, bit8;
    logic [CUR_BYTE_W-1:0] st_byte;
    logic [2:0]            st_p;
    logic [6:0]            pn;
    logic [7:0]            pn_up;
    logic [7:0]            m8;
    logic [15:0]           d16, mk16;
    t_status               e_status;
    logic [CUR_BYTE_W-1:0] e_byte;
    logic [CUR_BIT_W-1:0]  e_bit;
    logic                  e_go_rd, e_go_wr;

    // Memory port controls.
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          out_free;

    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {5'd0, r_out_bit, r_out_byte, r_out_status, r_out_value};

    // Cursor arithmetic and request checks.
    always_comb begin
        off_cur   = OFF_W'({r_cur_byte, 3'b000}) + OFF_W'(r_cur_bit);
        cap_eff   = (OFF_W'(r_capacity) > STORE_LIM) ? STORE_LIM : OFF_W'(r_capacity);
        cap_bits  = OFF_W'({cap_eff, 3'b000});
        free_bits = (cap_bits > off_cur) ? (cap_bits - off_cur) : '0;
        n17       = OFF_W'(r_n);
        over_free = (n17 > free_bits);
        bit8      = (r_cur_bit == 4'd8);
        st_byte   = bit8 ? (r_cur_byte + 13'd1) : r_cur_byte;
        st_p      = bit8 ? 3'd0 : r_cur_bit[2:0];
        end_m1    = off_cur + n17 - 17'd1;
        seek_off  = off_cur - n17;
        pn        = 7'(st_p) + r_n[6:0];
        pn_up     = 8'(pn) + 8'd7;
        m8        = ~(8'hFF >> r_n[3:0]);
        d16       = {r_wbyte & m8, 8'h00} >> st_p;
        mk16      = {m8, 8'h00} >> st_p;

        e_status = ST_OK;
        e_byte   = r_cur_byte;
        e_bit    = r_cur_bit;
        e_go_rd  = 1'b0;
        e_go_wr  = 1'b0;
        case (r_req)
            REQ_WRITE: begin
                if (r_n > 16'd8) begin
                    e_status = ST_RANGE;
                end else if (over_free) begin
                    e_status = ST_NOSPACE;
                end else if (r_n != '0) begin
                    e_go_wr = 1'b1;
                    e_byte  = CUR_BYTE_W'(end_m1 >> 3);
                    e_bit   = CUR_BIT_W'(end_m1[2:0]) + 4'd1;
                end
            end
            REQ_READ: begin
                if (r_n > 16'd64 || over_free) begin
                    e_status = ST_RANGE;
                end else if (r_n != '0) begin
                    e_go_rd = 1'b1;
                    e_byte  = CUR_BYTE_W'(end_m1 >> 3);
                    e_bit   = CUR_BIT_W'(end_m1[2:0]) + 4'd1;
                end
            end
            REQ_SEEK: begin
                if (n17 > off_cur) begin
                    e_status = ST_RANGE;
                    e_byte   = '0;
                    e_bit    = '0;
                end else if (n17 <= OFF_W'(r_cur_bit)) begin
                    e_bit = r_cur_bit - CUR_BIT_W'(r_n);
                end else begin
                    e_byte = CUR_BYTE_W'(seek_off >> 3);
                    e_bit  = CUR_BIT_W'(seek_off[2:0]);
                end
            end
            REQ_QUERY: begin
                if (over_free) begin
                    e_status = ST_NOSPACE;
                end
            end
            default: begin
                e_status = ST_OK;
            end
        endcase
    end

    // Memory port selection: one access per cycle.
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = (r_q & ~r_wm[15:8]) | r_wd[15:8];
        case (r_state)
            S_EVAL: begin
                mem_en   = e_go_rd || e_go_wr;
                mem_addr = AW'(st_byte);
            end
            S_RD: begin
                mem_en = (r_issue_left != 4'd0);
            end
            S_WA: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
            end
            S_WB: begin
                mem_en   = 1'b1;
                mem_addr = r_addr + AW'(1);
            end
            S_WC: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_addr + AW'(1);
                mem_wdata = (r_q & ~r_wm[7:0]) | r_wd[7:0];
            end
            default: begin
                mem_en = 1'b0;
            end
        endcase
    end

    // Byte store with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (mem_we) begin
                r_mem[mem_addr] <= mem_wdata;
            end else begin
                r_q <= r_mem[mem_addr];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (e_go_rd) begin
                    n_state = S_RD;
                end else if (e_go_wr) begin
                    n_state = S_WA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD: begin
                if (r_q_valid && r_cap_left == 4'd1) begin
                    n_state = S_FIN;
                end
            end
            S_WA: begin
                n_state = (r_wm[7:0] != 8'h00) ? S_WB : S_FIN;
            end
            S_WB: begin
                n_state = S_WC;
            end
            S_WC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, cursor and capacity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_cur_byte  <= '0;
            r_cur_bit   <= '0;
            r_out_valid <= 1'b0;
            r_q_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_q_valid <= mem_en && !mem_we && (r_state == S_EVAL || r_state == S_RD);
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (r_state == S_FIN && out_free) begin
                r_cur_byte  <= r_res_byte;
                r_cur_bit   <= r_res_bit;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request latch, work registers and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_req   <= t_req'(i_s_tuser);
            r_wbyte <= i_s_tdata[7:0];
            r_n     <= i_s_tdata[23:8];
        end
        if (r_state == S_EVAL) begin
            r_res_status <= e_status;
            r_res_byte   <= e_byte;
            r_res_bit    <= e_bit;
            r_val_en     <= e_go_rd;
            r_addr       <= e_go_rd ? (AW'(st_byte) + AW'(1)) : AW'(st_byte);
            r_p          <= st_p;
            r_drop       <= 3'd0 - pn[2:0];
            r_issue_left <= 4'(pn_up >> 3) - 4'd1;
            r_cap_left   <= 4'(pn_up >> 3);
            r_first      <= 1'b1;
            r_acc        <= '0;
            r_wd         <= d16;
            r_wm         <= mk16;
        end
        // Read: issue addresses back to back and shift in each returned byte.
        if (r_state == S_RD) begin
            if (r_issue_left != 4'd0) begin
                r_addr       <= r_addr + AW'(1);
                r_issue_left <= r_issue_left - 4'd1;
            end
            if (r_q_valid) begin
                r_acc      <= {r_acc[63:0], r_first ? (r_q & (8'hFF >> r_p)) : r_q};
                r_first    <= 1'b0;
                r_cap_left <= r_cap_left - 4'd1;
            end
        end
        if (r_state == S_FIN && out_free) begin
            r_out_value  <= r_val_en ? VALUE_W'(r_acc >> r_drop) : '0;
            r_out_status <= r_res_status;
            r_out_byte   <= r_res_byte;
            r_out_bit    <= r_res_bit;
        end
    end

    // Cursor bit position stays within a byte plus the full-byte form.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_bit <= 4'd8)
        else $error("cursor bit position above 8");

    // The cursor moves only when a result is handed to the output register.
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> ($stable(r_cur_byte) && $stable(r_cur_bit)))
        else $error("cursor moved outside the final state");

    // A read never waits on more bytes than it issued.
    a_rd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_cap_left != 4'd0 && r_issue_left < r_cap_left))
        else $error("read byte counters out of step");

endmodule

`default_nettype wire
